>>> hdl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

>>> hdl/spq_pkg.sv
// shared constants and types of the priority queue
package spq_pkg;
   localparam int CAPACITY_DEF      = 16;
   localparam int PRIORITY_BITS_DEF = 8;
   localparam int PAYLOAD_BITS_DEF  = 16;
   localparam int COUNT_BITS        = 5;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_READ   = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;
endpackage

>>> hdl/stable_priority_queue.sv
// top level of the stable priority queue
// use: one request beat on req_ gives exactly one result beat on rsp_.
// req_tdata carries the request kind, priority and payload; rsp_tdata the
// status, removed entry and count after the request.
// entries are kept sorted in one slot memory, ascending priority, equal
// priorities in arrival order. an insert moves the tail up one slot at a time
// from the top down; a read learns the top priority from the last slot, scans
// up from slot 0 for its earliest entry and then shifts the tail down.
// clear, no-op, insert into a full queue and read from an empty one go
// straight from idle to the result; an insert works longer the more entries
// move up, and a read walks every held slot wherever the entry sits.
// one request is in work at a time; req_tready is high only while idle, and
// comes back in the cycle the result beat shows up.
// the result sits in an output register until taken; with a stalled receiver
// the block still takes and works the next request, which then waits for the
// output register before going idle again.
// reset clears the count and the control state; slot contents are not
// cleared, only held slots are ever read.
module stable_priority_queue import spq_pkg::*; #(
   parameter int CAPACITY      = CAPACITY_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
   parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // req_type, item_priority, item_payload (lowest bit first), zero fill
   input  logic [((2+PRIORITY_BITS+PAYLOAD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // status, out_priority, out_payload, entry_count (lowest bit first), zero fill
   output logic [((2+PRIORITY_BITS+PAYLOAD_BITS+COUNT_BITS+7)/8)*8-1:0] rsp_tdata
);
`include "assert_macros.svh"
   localparam int AW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int EW  = PRIORITY_BITS + PAYLOAD_BITS;
   localparam int OW  = ((2+PRIORITY_BITS+PAYLOAD_BITS+COUNT_BITS+7)/8)*8;
   localparam int PAD = OW - (2+EW+COUNT_BITS);

   typedef enum logic [2:0] {
      S_IDLE, S_INS_RD, S_INS_WAIT, S_FIND, S_DEL, S_RESULT
   } state_type;

   state_type          state_ff;
   logic [CW-1:0]      count_ff;
   logic [AW:0]        idx_ff;      // current slot, one spare bit
   logic [PRIORITY_BITS-1:0] new_prio_ff, top_ff;
   logic [PAYLOAD_BITS-1:0]  new_pay_ff;
   logic               pend_ff;     // read data of slot pend_addr_ff valid now
   logic [AW-1:0]      pend_addr_ff;
   logic [1:0]         status_ff;
   logic [EW-1:0]      out_ent_ff;
   logic [CW-1:0]      rcount_ff;
   logic               rvalid_ff;
   // output register, free of the working state
   logic [1:0]         rsp_status_ff;
   logic [EW-1:0]      rsp_ent_ff;
   logic [CW-1:0]      rsp_count_ff;
   logic               rsp_load;

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [EW-1:0]      wr_data, rd_data;
   logic [PRIORITY_BITS-1:0] rd_prio;

   req_kind_type       kind;
   logic [PRIORITY_BITS-1:0] in_prio;
   logic [PAYLOAD_BITS-1:0]  in_pay;

   assign kind    = req_kind_type'(req_tdata[1:0]);
   assign in_prio = req_tdata[2 +: PRIORITY_BITS];
   assign in_pay  = req_tdata[2+PRIORITY_BITS +: PAYLOAD_BITS];
   assign rd_prio = rd_data[EW-1 -: PRIORITY_BITS];

   // result moves to the output register once that is empty or being taken
   assign rsp_load   = (state_ff == S_RESULT) && (!rvalid_ff || rsp_tready);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {{PAD{1'b0}}, COUNT_BITS'(rsp_count_ff),
                        rsp_ent_ff[PAYLOAD_BITS-1:0],
                        rsp_ent_ff[EW-1 -: PRIORITY_BITS], rsp_status_ff};

   spq_mem #(.DEPTH(CAPACITY), .WIDTH(EW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // insert: walk idx down from count-1; read slot idx, next cycle either
   //   move it to idx+1 (prio > new) or write new at idx+1 and finish.
   // find: read slot idx upward until prio == top; then del moves idx+1 to idx.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pend_addr_ff + AW'(1);
      wr_data = rd_data;
      rd_addr = idx_ff[AW-1:0];
      case (state_ff)
         S_INS_WAIT: begin
            wr_en = pend_ff;
            if (pend_ff && rd_prio <= new_prio_ff) begin
               wr_data = {new_prio_ff, new_pay_ff};
            end
         end
         S_INS_RD: begin
            if (idx_ff[AW]) begin  // below slot 0: place new at slot 0
               wr_en   = 1'b1;
               wr_addr = '0;
               wr_data = {new_prio_ff, new_pay_ff};
            end
         end
         S_DEL: begin
            wr_en   = pend_ff;
            wr_addr = pend_addr_ff - AW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         if (rsp_load)        rvalid_ff <= 1'b1;
         else if (rsp_tready) rvalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               pend_ff <= 1'b0;
               if (req_tvalid && req_tready) begin
                  new_prio_ff <= in_prio;
                  new_pay_ff  <= in_pay;
                  status_ff   <= ST_DONE;
                  out_ent_ff  <= '0;
                  rcount_ff   <= count_ff;
                  case (kind)
                     REQ_INSERT: begin
                        if (count_ff == CW'(CAPACITY)) begin
                           status_ff <= ST_FULL;
                           state_ff  <= S_RESULT;
                        end else begin
                           idx_ff   <= (AW+1)'(count_ff) - (AW+1)'(1);
                           state_ff <= S_INS_RD;
                        end
                     end
                     REQ_READ: begin
                        if (count_ff == '0) begin
                           status_ff <= ST_EMPTY;
                           state_ff  <= S_RESULT;
                        end else begin
                           // top entry lives in the last slot; read it first
                           idx_ff   <= (AW+1)'(count_ff) - (AW+1)'(1);
                           state_ff <= S_FIND;
                        end
                     end
                     REQ_CLEAR: begin
                        count_ff  <= '0;
                        rcount_ff <= '0;
                        state_ff  <= S_RESULT;
                     end
                     default: state_ff <= S_RESULT;
                  endcase
               end
            end
            S_INS_RD: begin
               if (idx_ff[AW]) begin
                  count_ff  <= count_ff + CW'(1);
                  rcount_ff <= count_ff + CW'(1);
                  state_ff  <= S_RESULT;
               end else begin
                  pend_ff      <= 1'b1;
                  pend_addr_ff <= idx_ff[AW-1:0];
                  state_ff     <= S_INS_WAIT;
               end
            end
            S_INS_WAIT: begin
               pend_ff <= 1'b0;
               if (rd_prio <= new_prio_ff) begin
                  count_ff  <= count_ff + CW'(1);
                  rcount_ff <= count_ff + CW'(1);
                  state_ff  <= S_RESULT;
               end else begin
                  idx_ff   <= idx_ff - (AW+1)'(1);
                  state_ff <= S_INS_RD;
               end
            end
            S_FIND: begin
               // pend_ff low: issuing read of top; high: data of pend_addr valid
               if (!pend_ff) begin
                  pend_ff      <= 1'b1;
                  pend_addr_ff <= idx_ff[AW-1:0];
                  top_ff       <= '0;
                  idx_ff       <= '0;
                  status_ff    <= ST_EMPTY; // marks top not yet known
               end else if (status_ff == ST_EMPTY) begin
                  top_ff       <= rd_prio;
                  status_ff    <= ST_DONE;
                  pend_addr_ff <= '0;
                  idx_ff       <= (AW+1)'(1);
               end else if (rd_prio == top_ff) begin
                  out_ent_ff   <= rd_data;
                  // shift slots pend+1 .. count-1 down one
                  pend_ff      <= 1'b0;
                  pend_addr_ff <= pend_addr_ff + AW'(1);
                  idx_ff       <= (AW+1)'(pend_addr_ff) + (AW+1)'(1);
                  state_ff     <= S_DEL;
               end else begin
                  pend_addr_ff <= idx_ff[AW-1:0];
                  idx_ff       <= idx_ff + (AW+1)'(1);
               end
            end
            S_DEL: begin
               if (idx_ff < (AW+1)'(count_ff)) begin
                  pend_ff      <= 1'b1;
                  pend_addr_ff <= idx_ff[AW-1:0];
                  idx_ff       <= idx_ff + (AW+1)'(1);
               end else begin
                  pend_ff   <= 1'b0;
                  count_ff  <= count_ff - CW'(1);
                  rcount_ff <= count_ff - CW'(1);
                  state_ff  <= S_RESULT;
               end
            end
            S_RESULT: begin
               pend_ff <= 1'b0;
               if (rsp_load) begin
                  rsp_status_ff <= status_ff;
                  rsp_ent_ff    <= out_ent_ff;
                  rsp_count_ff  <= rcount_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_IMPLIES(a_count_cap, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `ASSERT_IMPLIES(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !req_tready)
   `ASSERT_NEXT(a_result_follows, clock, reset, state_ff == S_RESULT, rvalid_ff)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rvalid_ff && !rsp_tready, rvalid_ff && $stable(rsp_tdata))
endmodule

>>> hdl/spq_mem.sv
// simple dual port slot memory with registered read data
module spq_mem import spq_pkg::*; #(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int WIDTH = PRIORITY_BITS_DEF + PAYLOAD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
